/* rtl/rate_neuron_stp_hebbian_step_defines.svh */
// Assertion helpers for the RTL, included by rnsh_ctrl.
`ifndef RATE_NEURON_STP_HEBBIAN_STEP_DEFINES_SVH
`define RATE_NEURON_STP_HEBBIAN_STEP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RNSH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rnsh assertion failed");

// Next-cycle implication, disabled during reset.
`define RNSH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rnsh assertion failed");

`endif

/* rtl/rnsh_pkg.sv */
package rnsh_pkg;

	localparam int SYNAPSES = 64;
	localparam int IDX_W    = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
	localparam int PC_W     = 6;

	localparam logic signed [63:0] Q_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] Q_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [63:0] Q_ONE = 64'sd1099511627776;
	localparam logic signed [63:0] INV_TAU_AMPA  = 64'sd109951162778;
	localparam logic signed [63:0] INV_TAU_DELTA = 64'sd1099511628;
	localparam logic signed [63:0] INV_TAU_STD   = 64'sd2199023256;
	localparam logic signed [63:0] INV_TAU_STP   = 64'sd5497558139;
	localparam logic signed [63:0] INV_TAU_ADP   = 64'sd13743895347;

	// register reset values
	localparam logic [62:0]        DT_RST    = 63'd109951162778;
	localparam logic signed [63:0] BIAS_RST  = 64'sd0;
	localparam logic [62:0]        THR_RST   = 63'd549755813888;
	localparam logic [62:0]        SLOPE_RST = 63'd2748779069;
	localparam logic [62:0]        LRATE_RST = 63'd4398046511104;
	localparam logic [40:0]        UBASE_RST = 41'd659706976665;
	localparam logic               STP_RST   = 1'b1;
	localparam logic signed [63:0] FAC_RST   = STP_RST ? {23'd0, UBASE_RST} : Q_ONE;

	typedef enum logic [2:0] {
		R_DT, R_BIAS, R_THR, R_SLOPE, R_LRATE, R_UBASE, R_STP
	} reg_t;

	typedef struct packed {
		logic [62:0]        dt;
		logic signed [63:0] bias;
		logic [62:0]        thr;
		logic [62:0]        slope;
		logic [62:0]        lrate;
		logic [40:0]        ubase;
		logic               stp_en;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_NEG, OP_CLAMP, OP_CMP, OP_GATE, OP_MUL
	} op_t;

	typedef enum logic [4:0] {
		S_R0, S_R1, S_R2, S_R3, S_W, S_TR, S_ACC, S_AMPA, S_OSPK, S_ADP, S_DEP, S_FAC,
		S_DT, S_BIAS, S_THR, S_SLOPE, S_LRATE, S_UBASE, S_PRATE, S_PSPK, S_ONE, S_ZERO,
		S_IAMPA, S_IDELTA, S_ISTD, S_ISTP, S_IADP
	} src_t;

	typedef enum logic [3:0] {
		D_R0, D_R1, D_R2, D_R3, D_W, D_TR, D_ACC, D_AMPA, D_OSPK, D_ADP, D_DEP, D_FAC,
		D_NONE
	} dst_t;

	typedef enum logic [1:0] {E_NONE, E_SYN, E_STP, E_OUT} end_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		dst_t dst;
		end_t eos;
	} uop_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_EXEC, ST_MWAIT, ST_WB, ST_OUTW
	} state_t;

	typedef struct packed {
		uop_t uop;
		logic take;
		logic wb;
		logic alu_wr;
		logic mul_start;
		logic mul_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic link_ok;
		logic last;
		logic stp_en;
		logic mul_done;
	} stat_t;

	localparam logic [PC_W-1:0] PC_SYN = 6'd0;
	localparam logic [PC_W-1:0] PC_STP = 6'd14;
	localparam logic [PC_W-1:0] PC_OUT = 6'd29;

	function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
		if (v[64] != v[63]) begin
			return v[64] ? Q_MIN : Q_MAX;
		end
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return sat65({a[63], a} + {b[63], b});
	endfunction

	function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return sat65({a[63], a} - {b[63], b});
	endfunction

	function automatic logic [62:0] clamp_out(input logic signed [63:0] v);
		return v[63] ? 63'd0 : v[62:0];
	endfunction

	// Step program: synapse update, plasticity update, output update.
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = '{OP_MUL,   S_DT,    S_TR,     D_R0,   E_NONE};
			6'd1:  u = '{OP_ADD,   S_W,     S_R0,     D_W,    E_NONE};
			6'd2:  u = '{OP_NEG,   S_TR,    S_ZERO,   D_R0,   E_NONE};
			6'd3:  u = '{OP_MUL,   S_DT,    S_R0,     D_R0,   E_NONE};
			6'd4:  u = '{OP_MUL,   S_R0,    S_IDELTA, D_R0,   E_NONE};
			6'd5:  u = '{OP_ADD,   S_TR,    S_R0,     D_TR,   E_NONE};
			6'd6:  u = '{OP_MUL,   S_DT,    S_LRATE,  D_R0,   E_NONE};
			6'd7:  u = '{OP_MUL,   S_R0,    S_IDELTA, D_R0,   E_NONE};
			6'd8:  u = '{OP_MUL,   S_R0,    S_ADP,    D_R0,   E_NONE};
			6'd9:  u = '{OP_MUL,   S_R0,    S_PSPK,   D_R0,   E_NONE};
			6'd10: u = '{OP_ADD,   S_TR,    S_R0,     D_TR,   E_NONE};
			6'd11: u = '{OP_CLAMP, S_W,     S_ZERO,   D_W,    E_NONE};
			6'd12: u = '{OP_MUL,   S_W,     S_PRATE,  D_R0,   E_NONE};
			6'd13: u = '{OP_ADD,   S_ACC,   S_R0,     D_ACC,  E_SYN};
			6'd14: u = '{OP_SUB,   S_ONE,   S_DEP,    D_R0,   E_NONE};
			6'd15: u = '{OP_MUL,   S_R0,    S_ISTD,   D_R0,   E_NONE};
			6'd16: u = '{OP_MUL,   S_DEP,   S_FAC,    D_R1,   E_NONE};
			6'd17: u = '{OP_MUL,   S_R1,    S_OSPK,   D_R1,   E_NONE};
			6'd18: u = '{OP_SUB,   S_R0,    S_R1,     D_R0,   E_NONE};
			6'd19: u = '{OP_MUL,   S_DT,    S_R0,     D_R0,   E_NONE};
			6'd20: u = '{OP_ADD,   S_DEP,   S_R0,     D_DEP,  E_NONE};
			6'd21: u = '{OP_SUB,   S_UBASE, S_FAC,    D_R0,   E_NONE};
			6'd22: u = '{OP_MUL,   S_R0,    S_ISTP,   D_R0,   E_NONE};
			6'd23: u = '{OP_SUB,   S_ONE,   S_FAC,    D_R1,   E_NONE};
			6'd24: u = '{OP_MUL,   S_UBASE, S_R1,     D_R1,   E_NONE};
			6'd25: u = '{OP_MUL,   S_R1,    S_OSPK,   D_R1,   E_NONE};
			6'd26: u = '{OP_ADD,   S_R0,    S_R1,     D_R0,   E_NONE};
			6'd27: u = '{OP_MUL,   S_DT,    S_R0,     D_R0,   E_NONE};
			6'd28: u = '{OP_ADD,   S_FAC,   S_R0,     D_FAC,  E_STP};
			6'd29: u = '{OP_MUL,   S_AMPA,  S_IAMPA,  D_R0,   E_NONE};
			6'd30: u = '{OP_NEG,   S_R0,    S_ZERO,   D_R0,   E_NONE};
			6'd31: u = '{OP_ADD,   S_R0,    S_ACC,    D_R0,   E_NONE};
			6'd32: u = '{OP_MUL,   S_DT,    S_R0,     D_R0,   E_NONE};
			6'd33: u = '{OP_ADD,   S_AMPA,  S_R0,     D_AMPA, E_NONE};
			6'd34: u = '{OP_ADD,   S_AMPA,  S_BIAS,   D_R2,   E_NONE};
			6'd35: u = '{OP_ADD,   S_ZERO,  S_ZERO,   D_ACC,  E_NONE};
			6'd36: u = '{OP_CMP,   S_R2,    S_THR,    D_NONE, E_NONE};
			6'd37: u = '{OP_SUB,   S_R2,    S_THR,    D_R0,   E_NONE};
			6'd38: u = '{OP_MUL,   S_SLOPE, S_R0,     D_R0,   E_NONE};
			6'd39: u = '{OP_GATE,  S_R0,    S_ZERO,   D_R3,   E_NONE};
			6'd40: u = '{OP_SUB,   S_R3,    S_ADP,    D_R0,   E_NONE};
			6'd41: u = '{OP_MUL,   S_R0,    S_IADP,   D_R0,   E_NONE};
			6'd42: u = '{OP_ADD,   S_ADP,   S_R0,     D_ADP,  E_NONE};
			6'd43: u = '{OP_MUL,   S_R3,    S_DEP,    D_R0,   E_NONE};
			6'd44: u = '{OP_MUL,   S_R0,    S_FAC,    D_R0,   E_NONE};
			6'd45: u = '{OP_ADD,   S_R3,    S_ZERO,   D_OSPK, E_OUT};
			default: u = '{OP_ADD, S_ZERO,  S_ZERO,   D_NONE, E_OUT};
		endcase
		return u;
	endfunction

endpackage

/* rtl/rnsh_mul.sv */
module rnsh_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res
);
	import rnsh_pkg::*;

	logic [63:0]        ma_q, mb_q;
	logic               neg_q;
	logic               busy_q;
	logic [2:0]         ph_q;
	logic [63:0]        pp_s1;
	logic [127:0]       acc_q;
	logic signed [63:0] res_q;
	logic               done_q;
	logic [2:0]         lph;
	logic [1:0]         words;
	logic [6:0]         sh;
	logic [31:0]        ah, bh;
	logic [63:0]        mag;
	logic signed [63:0] sat;

	// pick the half words of this phase and the weight of the previous product
	always_comb begin
		ah    = ph_q[1] ? ma_q[63:32] : ma_q[31:0];
		bh    = ph_q[0] ? mb_q[63:32] : mb_q[31:0];
		lph   = ph_q - 3'd1;
		words = {lph[1] & lph[0], lph[1] ^ lph[0]};
		sh    = {words, 5'd0};
	end

	// truncate the magnitude at bit 40 and saturate
	always_comb begin
		mag = acc_q[103:40];
		if (|acc_q[127:104]) begin
			sat = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			sat = mag[63] ? Q_MIN : -$signed(mag);
		end else begin
			sat = mag[63] ? Q_MAX : $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 3'd0;
			end else if (busy_q) begin
				if (ph_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	// one 32x32 partial product a cycle, registered and accumulated in the following cycle
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? 64'd0 - a : a;
			mb_q  <= b[63] ? 64'd0 - b : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (ph_q <= 3'd3) begin
				pp_s1 <= ah * bh;
			end
			if (ph_q >= 3'd1 && ph_q <= 3'd4) begin
				acc_q <= acc_q + (128'(pp_s1) << sh);
			end
			if (ph_q == 3'd5) begin
				res_q <= sat;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/rnsh_cfg.sv */
module rnsh_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output rnsh_pkg::cfg_t      cfg
);
	import rnsh_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign wr = psel & penable & pwrite;

	// write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dt     <= DT_RST;
			cfg_q.bias   <= BIAS_RST;
			cfg_q.thr    <= THR_RST;
			cfg_q.slope  <= SLOPE_RST;
			cfg_q.lrate  <= LRATE_RST;
			cfg_q.ubase  <= UBASE_RST;
			cfg_q.stp_en <= STP_RST;
		end else if (wr) begin
			unique case (paddr[5:3])
				R_DT:    cfg_q.dt     <= pwdata[62:0];
				R_BIAS:  cfg_q.bias   <= pwdata;
				R_THR:   cfg_q.thr    <= pwdata[62:0];
				R_SLOPE: cfg_q.slope  <= pwdata[62:0];
				R_LRATE: cfg_q.lrate  <= pwdata[62:0];
				R_UBASE: cfg_q.ubase  <= pwdata[40:0];
				R_STP:   cfg_q.stp_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[5:3])
			R_DT:    prdata = {1'b0, cfg_q.dt};
			R_BIAS:  prdata = cfg_q.bias;
			R_THR:   prdata = {1'b0, cfg_q.thr};
			R_SLOPE: prdata = {1'b0, cfg_q.slope};
			R_LRATE: prdata = {1'b0, cfg_q.lrate};
			R_UBASE: prdata = {23'd0, cfg_q.ubase};
			R_STP:   prdata = {63'd0, cfg_q.stp_en};
			default: prdata = 64'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/rnsh_dp.sv */
module rnsh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rnsh_pkg::cfg_t      cfg,
	input  rnsh_pkg::cmd_t      cmd,
	output rnsh_pkg::stat_t     stat,
	input  logic                mode,
	input  logic [5:0]          syn_index,
	input  logic [62:0]         initial_weight,
	input  logic                connected,
	input  logic [62:0]         pre_rate,
	input  logic [62:0]         pre_spike,
	input  logic                last,
	output logic [62:0]         rate_out,
	output logic [62:0]         spike_out,
	output logic signed [63:0]  current_out,
	output logic [62:0]         adp_out
);
	import rnsh_pkg::*;

	logic signed [63:0] wmem [SYNAPSES];
	logic signed [63:0] tmem [SYNAPSES];
	logic [SYNAPSES-1:0] link_q;

	logic [IDX_W-1:0]   addr, idx_q;
	logic               in_range;
	logic               link_ok_q, last_q, flag_q;
	logic [62:0]        prate_q, pspk_q;
	logic signed [63:0] r0_q, r1_q, r2_q, r3_q, w_q, tr_q;
	logic signed [63:0] acc_q, ampa_q, ospk_q, adp_q, dep_q, fac_q;
	logic signed [63:0] opa, opb, alu, wval, mres;
	logic               mdone, wen;
	logic [62:0]        rate_q, spike_q, adpo_q;
	logic signed [63:0] cur_q;

	assign addr     = IDX_W'(syn_index);
	assign in_range = 32'(syn_index) < SYNAPSES;

	function automatic logic signed [63:0] pick(input src_t s,
			input logic signed [63:0] r0, input logic signed [63:0] r1,
			input logic signed [63:0] r2, input logic signed [63:0] r3,
			input logic signed [63:0] w, input logic signed [63:0] tr,
			input logic signed [63:0] acc, input logic signed [63:0] ampa,
			input logic signed [63:0] ospk, input logic signed [63:0] adp,
			input logic signed [63:0] dep, input logic signed [63:0] fac,
			input cfg_t c, input logic [62:0] prate, input logic [62:0] pspk);
		case (s)
			S_R0:     return r0;
			S_R1:     return r1;
			S_R2:     return r2;
			S_R3:     return r3;
			S_W:      return w;
			S_TR:     return tr;
			S_ACC:    return acc;
			S_AMPA:   return ampa;
			S_OSPK:   return ospk;
			S_ADP:    return adp;
			S_DEP:    return dep;
			S_FAC:    return fac;
			S_DT:     return {1'b0, c.dt};
			S_BIAS:   return c.bias;
			S_THR:    return {1'b0, c.thr};
			S_SLOPE:  return {1'b0, c.slope};
			S_LRATE:  return {1'b0, c.lrate};
			S_UBASE:  return {23'd0, c.ubase};
			S_PRATE:  return {1'b0, prate};
			S_PSPK:   return {1'b0, pspk};
			S_ONE:    return Q_ONE;
			S_IAMPA:  return INV_TAU_AMPA;
			S_IDELTA: return INV_TAU_DELTA;
			S_ISTD:   return INV_TAU_STD;
			S_ISTP:   return INV_TAU_STP;
			S_IADP:   return INV_TAU_ADP;
			default:  return 64'sd0;
		endcase
	endfunction

	// operand select and combinational ALU ops
	always_comb begin
		opa = pick(cmd.uop.a, r0_q, r1_q, r2_q, r3_q, w_q, tr_q, acc_q, ampa_q, ospk_q,
			adp_q, dep_q, fac_q, cfg, prate_q, pspk_q);
		opb = pick(cmd.uop.b, r0_q, r1_q, r2_q, r3_q, w_q, tr_q, acc_q, ampa_q, ospk_q,
			adp_q, dep_q, fac_q, cfg, prate_q, pspk_q);
		case (cmd.uop.op)
			OP_ADD:   alu = qadd(opa, opb);
			OP_SUB:   alu = qsub(opa, opb);
			OP_NEG:   alu = qsub(64'sd0, opa);
			OP_CLAMP: alu = opa[63] ? 64'sd0 : opa;
			OP_GATE:  alu = flag_q ? opa : 64'sd0;
			default:  alu = 64'sd0;
		endcase
		wval = cmd.mul_wr ? mres : alu;
		wen  = cmd.alu_wr | cmd.mul_wr;
	end

	rnsh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (opa),
		.b      (opb),
		.done   (mdone),
		.res    (mres)
	);

	// connection flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (cmd.take && !mode && in_range) begin
			link_q[addr] <= connected;
		end
	end

	// synapse memories and their working copies
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (!mode) begin
				if (in_range) begin
					wmem[addr] <= {1'b0, initial_weight};
					tmem[addr] <= 64'sd0;
				end
			end else begin
				w_q  <= wmem[addr];
				tr_q <= tmem[addr];
			end
		end else if (cmd.wb) begin
			wmem[idx_q] <= w_q;
			tmem[idx_q] <= tr_q;
		end else if (wen) begin
			if (cmd.uop.dst == D_W) w_q <= wval;
			if (cmd.uop.dst == D_TR) tr_q <= wval;
		end
	end

	// latch the item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q     <= addr;
			link_ok_q <= in_range && link_q[addr];
			last_q    <= last;
			prate_q   <= pre_rate;
			pspk_q    <= pre_spike;
		end
	end

	// scratch registers and compare flag
	always_ff @(posedge clk) begin
		if (wen) begin
			case (cmd.uop.dst)
				D_R0:    r0_q <= wval;
				D_R1:    r1_q <= wval;
				D_R2:    r2_q <= wval;
				D_R3:    r3_q <= wval;
				default: ;
			endcase
			if (cmd.uop.op == OP_CMP) flag_q <= opa > opb;
		end
	end

	// neuron state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 64'sd0;
			ampa_q <= 64'sd0;
			ospk_q <= 64'sd0;
			adp_q  <= 64'sd0;
			dep_q  <= Q_ONE;
			fac_q  <= FAC_RST;
		end else if (wen) begin
			case (cmd.uop.dst)
				D_ACC:   acc_q  <= wval;
				D_AMPA:  ampa_q <= wval;
				D_OSPK:  ospk_q <= wval;
				D_ADP:   adp_q  <= wval;
				D_DEP:   dep_q  <= wval;
				D_FAC:   fac_q  <= wval;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rate_q  <= clamp_out(r0_q);
			spike_q <= clamp_out(r3_q);
			cur_q   <= r2_q;
			adpo_q  <= clamp_out(adp_q);
		end
	end

	assign stat.is_load  = ~mode;
	assign stat.link_ok  = link_ok_q;
	assign stat.last     = last_q;
	assign stat.stp_en   = cfg.stp_en;
	assign stat.mul_done = mdone;

	assign rate_out    = rate_q;
	assign spike_out   = spike_q;
	assign current_out = cur_q;
	assign adp_out     = adpo_q;

endmodule

/* rtl/rnsh_ctrl.sv */
`include "rate_neuron_stp_hebbian_step_defines.svh"

module rnsh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rnsh_pkg::stat_t  stat,
	output rnsh_pkg::cmd_t   cmd
);
	import rnsh_pkg::*;

	state_t          state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic            ov_q;
	uop_t            uop;
	logic            adv;

	assign uop      = ucode(pc_q);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= PC_SYN;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// sequence one item through the step program
	always_comb begin
		state_d       = state_q;
		pc_d          = pc_q;
		adv           = 1'b0;
		cmd           = '0;
		cmd.uop       = uop;
		cmd.take      = in_valid & in_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && !stat.is_load) state_d = ST_RD;
			end
			ST_RD: begin
				if (stat.link_ok) begin
					pc_d    = PC_SYN;
					state_d = ST_EXEC;
				end else if (stat.last) begin
					pc_d    = stat.stp_en ? PC_STP : PC_OUT;
					state_d = ST_EXEC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EXEC: begin
				if (uop.op == OP_MUL) begin
					cmd.mul_start = 1'b1;
					state_d       = ST_MWAIT;
				end else begin
					cmd.alu_wr = 1'b1;
					adv        = 1'b1;
				end
			end
			ST_MWAIT: begin
				if (stat.mul_done) begin
					cmd.mul_wr = 1'b1;
					adv        = 1'b1;
				end
			end
			ST_WB: begin
				cmd.wb = 1'b1;
				if (stat.last) begin
					pc_d    = stat.stp_en ? PC_STP : PC_OUT;
					state_d = ST_EXEC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUTW: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// advance the program at the end of an op
		if (adv) begin
			unique case (uop.eos)
				E_NONE: begin
					pc_d    = pc_q + 1'b1;
					state_d = ST_EXEC;
				end
				E_SYN: state_d = ST_WB;
				E_STP: begin
					pc_d    = PC_OUT;
					state_d = ST_EXEC;
				end
				E_OUT: state_d = ST_OUTW;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;

	`RNSH_ASSERT_NXT(a_mul_wait, cmd.mul_start, state_q == ST_MWAIT)
	`RNSH_ASSERT_IMP(a_done_in_wait, stat.mul_done, state_q == ST_MWAIT)
	`RNSH_ASSERT_IMP(a_no_overwrite, cmd.out_load, !ov_q || out_ready)
	`RNSH_ASSERT_NXT(a_tick_reads, cmd.take && !stat.is_load, state_q == ST_RD)

endmodule

/* rtl/rate_neuron_stp_hebbian_step.sv */
// channel | handshake            | payload
// config  | psel/penable/pwrite  | paddr[5:3] register, pwdata, prdata (64 bit)
// input   | in_valid/in_ready    | mode, syn_index, initial_weight, connected,
//         |                      | pre_rate, pre_spike, last
// output  | out_valid/out_ready  | rate_out, spike_out, current_out, adp_out
//
// A load item is taken while idle and the block stays idle. A tick item runs
// through one shared 64x64 multiplier built from four 32x32 partial products:
// each product is issued in EXEC and waits in MWAIT, and an add is written in
// EXEC. A tick is taken, then reads its synapse in RD; a connected synapse then
// runs the synapse program and a write-back in WB. The last synapse then runs
// the plasticity update when enabled and the output update, then loads the
// result register. Reset clears configuration, link flags and neuron state
// asynchronously; no clearing pass. The input is held off while an item runs;
// a result waits in the output register while the next item is taken, and a
// finishing item stalls only if that register is still full.
module rate_neuron_stp_hebbian_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [5:0]         syn_index,
	input  logic [62:0]        initial_weight,
	input  logic               connected,
	input  logic [62:0]        pre_rate,
	input  logic [62:0]        pre_spike,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [62:0]        rate_out,
	output logic [62:0]        spike_out,
	output logic signed [63:0] current_out,
	output logic [62:0]        adp_out
);
	import rnsh_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;

	rnsh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rnsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rnsh_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode),
		.syn_index      (syn_index),
		.initial_weight (initial_weight),
		.connected      (connected),
		.pre_rate       (pre_rate),
		.pre_spike      (pre_spike),
		.last           (last),
		.rate_out       (rate_out),
		.spike_out      (spike_out),
		.current_out    (current_out),
		.adp_out        (adp_out)
	);

endmodule

/* test/tb_rate_neuron_stp_hebbian_step.sv */
module tb_rate_neuron_stp_hebbian_step;
	timeunit 1ns;
	timeprecision 1ps;

	import rnsh_pkg::*;

	typedef struct {
		logic        mode;
		logic [5:0]  syn_index;
		logic [62:0] initial_weight;
		logic        connected;
		logic [62:0] pre_rate;
		logic [62:0] pre_spike;
		logic        last;
	} syn_item_t;

	typedef struct {
		logic [62:0]        rate;
		logic [62:0]        spike;
		logic signed [63:0] current;
		logic [62:0]        adp;
	} neuron_out_t;

	// Fixed-point neuron predictor and the queue of outputs it still awaits
	class neuron_scoreboard;
		logic signed [63:0] dt, bias, thr, slope, lrate, ubase;
		logic               stp_on;
		logic signed [63:0] weight[SYNAPSES];
		logic signed [63:0] trace[SYNAPSES];
		logic               linked[SYNAPSES];
		logic signed [63:0] accum, ampa, last_spike, adp, dep, fac;
		neuron_out_t        awaited[$];
		int                 errors;

		function new();
			dt = 64'(DT_RST);
			bias = BIAS_RST;
			thr = 64'(THR_RST);
			slope = 64'(SLOPE_RST);
			lrate = 64'(LRATE_RST);
			ubase = 64'(UBASE_RST);
			stp_on = 1'b1;
			for (int i = 0; i < SYNAPSES; i++) begin
				weight[i] = 0;
				trace[i] = 0;
				linked[i] = 0;
			end
			accum = 0;
			ampa = 0;
			last_spike = 0;
			adp = 0;
			dep = Q_ONE;
			fac = stp_on ? ubase : Q_ONE;
			errors = 0;
		endfunction

		function logic signed [63:0] sat_sum(logic signed [64:0] v);
			if (v[64] != v[63]) begin
				return v[64] ? Q_MIN : Q_MAX;
			end
			return v[63:0];
		endfunction

		function logic signed [63:0] plus(logic signed [63:0] a, logic signed [63:0] b);
			return sat_sum({a[63], a} + {b[63], b});
		endfunction

		function logic signed [63:0] minus(logic signed [63:0] a, logic signed [63:0] b);
			return sat_sum({a[63], a} - {b[63], b});
		endfunction

		// Truncate the exact product toward zero, then saturate
		function logic signed [63:0] times(logic signed [63:0] a, logic signed [63:0] b);
			logic [63:0]  ma, mb;
			logic [127:0] p;
			logic [87:0]  m;
			logic         neg;
			neg = a[63] ^ b[63];
			ma = a[63] ? 64'(-a) : 64'(a);
			mb = b[63] ? 64'(-b) : 64'(b);
			p = {64'd0, ma} * {64'd0, mb};
			m = p[127:40];
			if (neg) begin
				if (m >= 88'h8000000000000000) return Q_MIN;
				return -$signed(m[63:0]);
			end
			if (m > 88'h7FFFFFFFFFFFFFFF) return Q_MAX;
			return $signed(m[63:0]);
		endfunction

		function logic [62:0] clip(logic signed [63:0] v);
			return v[63] ? 63'd0 : v[62:0];
		endfunction

		function void set_reg(reg_t r, logic [63:0] v);
			case (r)
				R_DT:    dt = {1'b0, v[62:0]};
				R_BIAS:  bias = v;
				R_THR:   thr = {1'b0, v[62:0]};
				R_SLOPE: slope = {1'b0, v[62:0]};
				R_LRATE: lrate = {1'b0, v[62:0]};
				R_UBASE: ubase = {23'd0, v[40:0]};
				R_STP:   stp_on = v[0];
				default: ;
			endcase
		endfunction

		function void note_input(syn_item_t it);
			logic signed [63:0] w, tr, t, cur, spk, d_old, f_old;
			neuron_out_t        nxt;
			int                 k;
			k = it.syn_index;
			if (it.mode == 1'b0) begin
				weight[k] = {1'b0, it.initial_weight};
				trace[k] = 0;
				linked[k] = it.connected;
				return;
			end
			if (linked[k]) begin
				w = plus(weight[k], times(dt, trace[k]));
				tr = plus(trace[k], times(times(dt, minus(0, trace[k])), INV_TAU_DELTA));
				t = times(times(times(times(dt, lrate), INV_TAU_DELTA), adp),
					{1'b0, it.pre_spike});
				tr = plus(tr, t);
				if (w[63]) w = 0;
				weight[k] = w;
				trace[k] = tr;
				accum = plus(accum, times(w, {1'b0, it.pre_rate}));
			end
			if (!it.last) return;
			// Depression and facilitation use the previous output spike rate
			if (stp_on) begin
				d_old = dep;
				f_old = fac;
				t = minus(times(minus(Q_ONE, d_old), INV_TAU_STD),
					times(times(d_old, f_old), last_spike));
				dep = plus(d_old, times(dt, t));
				t = plus(times(minus(ubase, f_old), INV_TAU_STP),
					times(times(ubase, minus(Q_ONE, f_old)), last_spike));
				fac = plus(f_old, times(dt, t));
			end
			t = plus(minus(0, times(ampa, INV_TAU_AMPA)), accum);
			ampa = plus(ampa, times(dt, t));
			cur = plus(ampa, bias);
			accum = 0;
			spk = (cur > thr) ? times(slope, minus(cur, thr)) : 64'sd0;
			adp = plus(adp, times(minus(spk, adp), INV_TAU_ADP));
			t = times(times(spk, dep), fac);
			last_spike = spk;
			nxt = '{clip(t), clip(spk), cur, clip(adp)};
			awaited.insert(awaited.size(), nxt);
		endfunction

		function void check_result(neuron_out_t got);
			neuron_out_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected output rate %h spike %h current %h adp %h",
					$time, got.rate, got.spike, got.current, got.adp);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.rate !== want.rate) begin
				$display("%0t: rate_out expected %h actual %h", $time, want.rate, got.rate);
				errors++;
			end
			if (got.spike !== want.spike) begin
				$display("%0t: spike_out expected %h actual %h", $time, want.spike, got.spike);
				errors++;
			end
			if (got.current !== want.current) begin
				$display("%0t: current_out expected %h actual %h", $time, want.current,
					got.current);
				errors++;
			end
			if (got.adp !== want.adp) begin
				$display("%0t: adp_out expected %h actual %h", $time, want.adp, got.adp);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               mode = 1'b0;
	logic [5:0]         syn_index = '0;
	logic [62:0]        initial_weight = '0;
	logic               connected = 1'b0;
	logic [62:0]        pre_rate = '0;
	logic [62:0]        pre_spike = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [62:0]        rate_out;
	logic [62:0]        spike_out;
	logic signed [63:0] current_out;
	logic [62:0]        adp_out;

	neuron_scoreboard sb = new();
	bit               calm = 0;
	bit               hold_req = 0;
	int               quiet_cycles = 0;

	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE = 300;

	rate_neuron_stp_hebbian_step dut (.*);

	always #5 clk = ~clk;

	// Check each output item as it is taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{rate_out, spike_out, current_out, adp_out});
	end

	// Watchdog: count cycles in which no handshake completes
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Mostly modest magnitudes, with full-width values mixed in
	function automatic logic [62:0] pick_q();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 63'({$urandom_range(0, 7), 40'd0}) | 63'({$urandom, $urandom} >> 24);
		if (r < 8) return 63'($urandom);
		return 63'({$urandom, $urandom});
	endfunction

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready = 1'b0;
				repeat (600) @(negedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_ready = 1'b0;
					repeat (n) @(negedge clk);
				end
			end
			out_ready = 1'b1;
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at a falling edge
	task automatic send_item(syn_item_t it);
		int n;
		n = pick_gap();
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		mode = it.mode;
		syn_index = it.syn_index;
		initial_weight = it.initial_weight;
		connected = it.connected;
		pre_rate = it.pre_rate;
		pre_spike = it.pre_spike;
		last = it.last;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic load_syn(int k, logic [62:0] w, logic c, logic l);
		send_item('{1'b0, 6'(k), w, c, pick_q(), pick_q(), l});
	endtask

	task automatic tick_syn(int k, logic [62:0] r, logic [62:0] s, logic l);
		send_item('{1'b1, 6'(k), pick_q(), 1'($urandom), r, s, l});
	endtask

	// Let every awaited output arrive and the block go quiet
	task automatic drain();
		in_valid = 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(reg_t r, logic [63:0] v);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {r, 3'b000};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		sb.set_reg(r, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic write_all(logic [63:0] v_dt, logic [63:0] v_bias, logic [63:0] v_thr,
			logic [63:0] v_slope, logic [63:0] v_lrate, logic [63:0] v_ubase, logic v_stp);
		write_reg(R_DT, v_dt);
		write_reg(R_BIAS, v_bias);
		write_reg(R_THR, v_thr);
		write_reg(R_SLOPE, v_slope);
		write_reg(R_LRATE, v_lrate);
		write_reg(R_UBASE, v_ubase);
		write_reg(R_STP, {63'd0, v_stp});
	endtask

	// Well-formed steps with random content, some noise mixed in
	task automatic random_phase(int items);
		int sent, n;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					load_syn($urandom_range(0, SYNAPSES - 1), pick_q(), $urandom_range(0, 7) != 0,
						1'($urandom));
					sent++;
				end
			end
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					tick_syn($urandom_range(0, SYNAPSES - 1), pick_q(), pick_q(), 1'($urandom));
				else
					tick_syn($urandom_range(0, SYNAPSES - 1), pick_q(), pick_q(), i == n - 1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, unconnected and unloaded synapses, load with last
		load_syn(0, 63'(Q_ONE), 1'b1, 1'b0);
		load_syn(1, {63{1'b1}}, 1'b1, 1'b0);
		load_syn(63, 63'd0, 1'b1, 1'b1);
		load_syn(5, {63{1'b1}}, 1'b0, 1'b0);
		load_syn(7, 63'(Q_ONE) << 2, 1'b1, 1'b0);
		tick_syn(0, 63'(Q_ONE) * 10, 63'(Q_ONE) * 5, 1'b0);
		tick_syn(5, {63{1'b1}}, {63{1'b1}}, 1'b0);
		tick_syn(63, {63{1'b1}}, 63'd0, 1'b1);
		tick_syn(7, 63'(Q_ONE) * 100, 63'(Q_ONE) * 50, 1'b1);
		tick_syn(7, 63'(Q_ONE) * 100, 63'(Q_ONE) * 50, 1'b1);
		tick_syn(2, {63{1'b1}}, {63{1'b1}}, 1'b1);
		tick_syn(1, 63'd0, 63'd0, 1'b1);
		tick_syn(1, {63{1'b1}}, {63{1'b1}}, 1'b1);
		tick_syn(0, 63'd0, {63{1'b1}}, 1'b1);
		tick_syn(7, 63'd1, 63'd1, 1'b1);
		drain();

		// Random register settings
		write_all({$urandom_range(0, 255), $urandom}, {$urandom_range(0, 7), $urandom},
			{$urandom_range(0, 255), $urandom}, {$urandom_range(0, 255), $urandom},
			{$urandom_range(0, 4095), $urandom}, {$urandom_range(0, 511), $urandom}, 1'b1);
		random_phase(260);
		drain();

		// Upper extremes with bias most negative, short-term plasticity off
		write_all({1'b0, {63{1'b1}}}, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}},
			{1'b0, {63{1'b1}}}, {23'd0, {41{1'b1}}}, 1'b0);
		random_phase(150);
		drain();

		// Lower extremes with bias most positive, short-term plasticity on
		write_all(64'd0, {1'b0, {63{1'b1}}}, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
		random_phase(150);
		drain();

		// Default-like settings; stall the output while the input keeps coming
		write_all(64'(DT_RST), 64'(Q_ONE), 64'(THR_RST), 64'(SLOPE_RST) << 8,
			64'(LRATE_RST), 64'(UBASE_RST), 1'b1);
		calm = 1;
		hold_req = 1;
		random_phase(150);
		calm = 0;
		random_phase(300);
		drain();

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/rnsh_pkg.sv
rtl/rnsh_mul.sv
rtl/rnsh_cfg.sv
rtl/rnsh_dp.sv
rtl/rnsh_ctrl.sv
rtl/rate_neuron_stp_hebbian_step.sv
test/tb_rate_neuron_stp_hebbian_step.sv
